// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent checks on a clk / arst_n domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition implies a property in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/core/hrw_pkg.sv -----
// ----------------------------------------------------------------------------
// hrw_pkg
// Types and constants of the TCP/IPv4 reply header rewrite unit.
// ----------------------------------------------------------------------------
package hrw_pkg;

	// Mode codes (s_tuser)
	localparam logic [1:0] FUNC_REPLY    = 2'd0;
	localparam logic [1:0] FUNC_CONTINUE = 2'd1;

	// Status codes (m_tuser)
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BADMODE = 2'd1;
	localparam logic [1:0] STATUS_SHORT   = 2'd2;

	// Header constants
	localparam logic [31:0] TS_INCREMENT   = 32'd20001;
	localparam logic [7:0]  NEW_TTL        = 8'd64;
	localparam logic [7:0]  TS_KIND        = 8'd8;
	localparam logic [7:0]  TS_LEN         = 8'd10;
	localparam logic [3:0]  TS_MIN_WORDS   = 4'd8;   // 32 bytes
	localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;   // 20 bytes

	// Input fields, first field in the highest bits
	typedef struct packed {
		logic [15:0] ident_in;
		logic [63:0] addr_pair_in;
		logic [15:0] l3_to_payload_len;
		logic [15:0] payload_len;
		logic [63:0] stamp_pair_in;
		logic [15:0] option_kind_len;
		logic [3:0]  header_words;
		logic [31:0] ack_in;
		logic [31:0] seq_in;
		logic [31:0] port_pair;
	} in_fields_t;

	// Result fields, first field in the highest bits
	typedef struct packed {
		logic [63:0] addr_pair_out;
		logic [15:0] ident_out;
		logic [7:0]  ttl_out;
		logic [15:0] total_len_out;
		logic [63:0] stamp_pair_out;
		logic [31:0] ack_out;
		logic [31:0] seq_out;
		logic [31:0] port_pair_out;
	} out_fields_t;

	localparam int IN_BITS     = $bits(in_fields_t);
	localparam int OUT_BITS    = $bits(out_fields_t);
	localparam int S_DATA_BITS = ((IN_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

endpackage

// ----- rtl/core/hrw_rewrite.sv -----
// ----------------------------------------------------------------------------
// hrw_rewrite
// Combinational rewrite of one header item: swaps, sequence and
// timestamp arithmetic, IP length, TTL and id, and the status code.
// ----------------------------------------------------------------------------
module hrw_rewrite (
	input  logic [1:0]          func,
	input  hrw_pkg::in_fields_t in_f,
	output logic [1:0]          status,
	output hrw_pkg::out_fields_t out_f
);

	logic        ts_ge32;
	logic        hdr_short;
	logic        ts_opt_ok;
	logic [31:0] seq_plus_len;
	logic [15:0] total_len;
	logic [15:0] ident_inc;
	logic [31:0] ts_val_inc;

	// Header size and option tests
	assign ts_ge32   = (in_f.header_words >= hrw_pkg::TS_MIN_WORDS);
	assign hdr_short = (in_f.header_words < hrw_pkg::MIN_HDR_WORDS);
	assign ts_opt_ok = (in_f.option_kind_len[15:8] == hrw_pkg::TS_KIND) &&
	                   (in_f.option_kind_len[7:0] == hrw_pkg::TS_LEN);

	// Independent adders, all wrap at field width
	assign seq_plus_len = in_f.seq_in + {16'd0, in_f.payload_len};
	assign total_len    = in_f.l3_to_payload_len + in_f.payload_len;
	assign ident_inc    = in_f.ident_in + 16'd1;
	assign ts_val_inc   = in_f.stamp_pair_in[63:32] + hrw_pkg::TS_INCREMENT;

	// Select rewritten fields by mode
	always_comb begin
		out_f.port_pair_out  = in_f.port_pair;
		out_f.seq_out        = in_f.seq_in;
		out_f.ack_out        = in_f.ack_in;
		out_f.stamp_pair_out = in_f.stamp_pair_in;
		out_f.addr_pair_out  = in_f.addr_pair_in;
		out_f.total_len_out  = '0;
		out_f.ttl_out        = '0;
		out_f.ident_out      = in_f.ident_in;
		status               = hrw_pkg::STATUS_BADMODE;
		case (func)
			hrw_pkg::FUNC_REPLY: begin
				out_f.port_pair_out = {in_f.port_pair[15:0], in_f.port_pair[31:16]};
				out_f.addr_pair_out = {in_f.addr_pair_in[31:0], in_f.addr_pair_in[63:32]};
				out_f.seq_out       = in_f.ack_in;
				out_f.ack_out       = seq_plus_len;
				if (ts_ge32 && ts_opt_ok) begin
					out_f.stamp_pair_out = {in_f.stamp_pair_in[31:0],
					                        in_f.stamp_pair_in[63:32]};
				end
			end
			hrw_pkg::FUNC_CONTINUE: begin
				out_f.seq_out = seq_plus_len;
				if (ts_ge32) begin
					out_f.stamp_pair_out = {ts_val_inc, in_f.stamp_pair_in[31:0]};
				end
			end
			default: begin
				status = hrw_pkg::STATUS_BADMODE;
			end
		endcase
		// IP fields for a valid mode
		if ((func == hrw_pkg::FUNC_REPLY) || (func == hrw_pkg::FUNC_CONTINUE)) begin
			out_f.total_len_out = total_len;
			out_f.ttl_out       = hrw_pkg::NEW_TTL;
			out_f.ident_out     = ident_inc;
			status = hdr_short ? hrw_pkg::STATUS_SHORT : hrw_pkg::STATUS_OK;
		end
	end

endmodule

// ----- rtl/core/tcp_ip_reply_header_rewrite_unit.sv -----
// ----------------------------------------------------------------------------
// tcp_ip_reply_header_rewrite_unit
// Rewrites the TCP and IPv4 header fields of one packet per item for a
// reply or a continued segment.
// ----------------------------------------------------------------------------
// Takes one header item per clock and gives one result item per clock
// while the downstream side takes results: the item is captured in an input
// register, rewritten by a short layer of swaps and independent adders,
// and held in a result register until the downstream side takes it.
// Stalls on the output propagate back through the two register stages,
// which keep running full while the downstream side keeps up.
// s_tuser carries the mode (0 reply, 1 continue); m_tuser carries the
// status (0 ok, 1 invalid mode with fields passed through, 2 TCP header
// under 20 bytes).
// ----------------------------------------------------------------------------
module tcp_ip_reply_header_rewrite_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// port_pair, seq_in, ack_in, header_words, option_kind_len,
	// stamp_pair_in, payload_len, l3_to_payload_len, addr_pair_in,
	// ident_in, zero fill
	input  logic [hrw_pkg::S_DATA_BITS-1:0] s_tdata,
	// func
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// port_pair_out, seq_out, ack_out, stamp_pair_out, total_len_out,
	// ttl_out, ident_out, addr_pair_out
	output logic [hrw_pkg::M_DATA_BITS-1:0] m_tdata,
	// status
	output logic [1:0]                      m_tuser
);

	logic                 valid_s1;
	hrw_pkg::in_fields_t  fields_s1;
	logic [1:0]           func_s1;
	logic                 valid_s2;
	hrw_pkg::out_fields_t fields_s2;
	logic [1:0]           status_s2;
	hrw_pkg::out_fields_t rw_fields;
	logic [1:0]           rw_status;
	logic                 load_s2;
	logic                 load_s1;

	// Stage handshakes
	assign load_s2  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || load_s2;
	assign load_s1  = s_tvalid && s_tready;

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture input item
	always_ff @(posedge clk) begin
		if (load_s1) begin
			fields_s1 <= hrw_pkg::in_fields_t'(s_tdata[hrw_pkg::IN_BITS-1:0]);
			func_s1   <= s_tuser;
		end
	end

	hrw_rewrite u_rewrite (
		.func   (func_s1),
		.in_f   (fields_s1),
		.status (rw_status),
		.out_f  (rw_fields)
	);

	// Hold result until taken
	always_ff @(posedge clk) begin
		if (load_s2) begin
			fields_s2 <= rw_fields;
			status_s2 <= rw_status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = hrw_pkg::M_DATA_BITS'(fields_s2);
	assign m_tuser  = status_s2;

endmodule

// ----- rtl/core/hrw_checker.sv -----
// ----------------------------------------------------------------------------
// hrw_checker
// Port-level checks on the header rewrite unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [hrw_pkg::M_DATA_BITS-1:0] m_tdata,
	input logic [1:0]                      m_tuser
);

	hrw_pkg::out_fields_t res;
	logic                 out_free;
	logic                 status_known;
	logic                 bad_mode;
	logic                 ip_zero;

	assign res = hrw_pkg::out_fields_t'(m_tdata[hrw_pkg::OUT_BITS-1:0]);

	assign out_free     = !m_tvalid || m_tready;
	assign bad_mode     = (m_tuser == hrw_pkg::STATUS_BADMODE);
	assign status_known = (m_tuser == hrw_pkg::STATUS_OK) || bad_mode ||
	                      (m_tuser == hrw_pkg::STATUS_SHORT);
	assign ip_zero      = (res.ttl_out == 8'd0) && (res.total_len_out == 16'd0);

	// A stalled result stays offered and unchanged
	`ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result dropped or changed")

	// Input is never held off while the output side has room
	`ASSERT_CLK(a_ready_free, !out_free || s_tready, "input stalled with room downstream")

	// No status code outside the defined set
	`ASSERT_CLK(a_status_code, !m_tvalid || status_known, "undefined status")

	// TTL and length follow the status
	`ASSERT_CLK(a_ttl_ok, !m_tvalid || bad_mode || (res.ttl_out == hrw_pkg::NEW_TTL), "TTL not set on valid mode")
	`ASSERT_CLK(a_badmode_zero, !m_tvalid || !bad_mode || ip_zero, "IP fields set on bad mode")

endmodule

bind tcp_ip_reply_header_rewrite_unit hrw_checker u_hrw_checker (.*);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TCP/IPv4 reply header rewrite unit: a driver
// streams queued header items with random gaps, a monitor takes results
// with random stalls and compares each one against a local rewrite model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	// Expected result: status plus rewritten fields
	typedef struct packed {
		logic [1:0]           status;
		hrw_pkg::out_fields_t fields;
	} rewrite_t;

	// Header item waiting to be sent, with the idle cycles that follow it
	typedef struct {
		logic [1:0]          mode;
		hrw_pkg::in_fields_t hdr;
		int                  gap;
	} queued_header_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [hrw_pkg::S_DATA_BITS-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [hrw_pkg::M_DATA_BITS-1:0] m_tdata;
	logic [1:0] m_tuser;

	queued_header_t headers_to_send[$];
	rewrite_t       rewrites_due[$];
	queued_header_t next_hdr;
	int  headers_queued = 0;
	int  send_wait = 0;
	int  current_gap = 0;
	int  recv_wait = 0;
	int  replies_checked = 0;
	int  hold_left = 0;
	int  next_hold_at = 400;
	bit  mismatch_seen = 1'b0;

	tcp_ip_reply_header_rewrite_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// Rewrite one header the way the unit should
	function automatic rewrite_t rewrite_header(logic [1:0] mode, hrw_pkg::in_fields_t h);
		rewrite_t r;
		logic [31:0] stamp_val;
		r.status               = hrw_pkg::STATUS_OK;
		r.fields.port_pair_out  = h.port_pair;
		r.fields.seq_out        = h.seq_in;
		r.fields.ack_out        = h.ack_in;
		r.fields.stamp_pair_out = h.stamp_pair_in;
		r.fields.total_len_out  = '0;
		r.fields.ttl_out        = '0;
		r.fields.ident_out      = h.ident_in;
		r.fields.addr_pair_out  = h.addr_pair_in;
		case (mode)
			hrw_pkg::FUNC_REPLY: begin
				r.fields.port_pair_out = {h.port_pair[15:0], h.port_pair[31:16]};
				r.fields.addr_pair_out = {h.addr_pair_in[31:0], h.addr_pair_in[63:32]};
				r.fields.seq_out       = h.ack_in;
				r.fields.ack_out       = h.seq_in + {16'd0, h.payload_len};
				// swap value and echo only for a real timestamp option
				if (h.header_words >= hrw_pkg::TS_MIN_WORDS &&
				    h.option_kind_len == {hrw_pkg::TS_KIND, hrw_pkg::TS_LEN})
					r.fields.stamp_pair_out = {h.stamp_pair_in[31:0], h.stamp_pair_in[63:32]};
			end
			hrw_pkg::FUNC_CONTINUE: begin
				r.fields.seq_out = h.seq_in + {16'd0, h.payload_len};
				// bump the value whatever the option kind says
				if (h.header_words >= hrw_pkg::TS_MIN_WORDS) begin
					stamp_val = h.stamp_pair_in[63:32] + hrw_pkg::TS_INCREMENT;
					r.fields.stamp_pair_out = {stamp_val, h.stamp_pair_in[31:0]};
				end
			end
			default: r.status = hrw_pkg::STATUS_BADMODE;
		endcase
		if (r.status == hrw_pkg::STATUS_OK) begin
			r.fields.total_len_out = h.l3_to_payload_len + h.payload_len;
			r.fields.ttl_out       = hrw_pkg::NEW_TTL;
			r.fields.ident_out     = h.ident_in + 16'd1;
			if (h.header_words < hrw_pkg::MIN_HDR_WORDS)
				r.status = hrw_pkg::STATUS_SHORT;
		end
		return r;
	endfunction

	function automatic hrw_pkg::in_fields_t random_header();
		hrw_pkg::in_fields_t h;
		h.port_pair         = $urandom;
		h.seq_in            = $urandom;
		h.ack_in            = $urandom;
		h.header_words      = 4'($urandom_range(0, 15));
		h.option_kind_len   = 16'($urandom_range(0, 65535));
		h.stamp_pair_in     = {$urandom, $urandom};
		h.payload_len       = 16'($urandom_range(0, 65535));
		h.l3_to_payload_len = 16'($urandom_range(0, 65535));
		h.addr_pair_in      = {$urandom, $urandom};
		h.ident_in          = 16'($urandom_range(0, 65535));
		return h;
	endfunction

	// Append an item; some stretches go out back to back
	task automatic queue_header(logic [1:0] mode, hrw_pkg::in_fields_t h);
		queued_header_t q;
		q.mode = mode;
		q.hdr  = h;
		q.gap  = (((headers_queued / 150) % 4) == 0) ? 0 : $urandom_range(0, 3);
		headers_to_send.push_back(q);
		headers_queued++;
	endtask

	// Random header with the mode, data offset and option word forced
	task automatic queue_case(logic [1:0] mode, logic [3:0] words, logic [15:0] kind_len);
		hrw_pkg::in_fields_t h;
		h = random_header();
		h.header_words    = words;
		h.option_kind_len = kind_len;
		queue_header(mode, h);
	endtask

	task automatic check_field(input string label, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %h, actual %h", $time, label, want, got);
			mismatch_seen = 1'b1;
		end
	endtask

	// Drive: record the item taken at this edge, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				rewrites_due.push_back(rewrite_header(s_tuser,
					s_tdata[hrw_pkg::IN_BITS-1:0]));
				send_wait = current_gap;
			end
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (headers_to_send.size() > 0) begin
					next_hdr = headers_to_send.pop_front();
					current_gap = next_hdr.gap;
					s_tvalid <= 1'b1;
					s_tdata  <= {{(hrw_pkg::S_DATA_BITS - hrw_pkg::IN_BITS){1'b0}},
					             next_hdr.hdr};
					s_tuser  <= next_hdr.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result item with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		rewrite_t             want;
		hrw_pkg::out_fields_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (rewrites_due.size() == 0) begin
					$display("%0t mismatch result: expected none, actual %h", $time, m_tdata);
					mismatch_seen = 1'b1;
				end else begin
					want = rewrites_due.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("port_pair_out", want.fields.port_pair_out, got.port_pair_out);
					check_field("seq_out", want.fields.seq_out, got.seq_out);
					check_field("ack_out", want.fields.ack_out, got.ack_out);
					check_field("stamp_pair_out", want.fields.stamp_pair_out,
						got.stamp_pair_out);
					check_field("total_len_out", want.fields.total_len_out, got.total_len_out);
					check_field("ttl_out", want.fields.ttl_out, got.ttl_out);
					check_field("ident_out", want.fields.ident_out, got.ident_out);
					check_field("addr_pair_out", want.fields.addr_pair_out, got.addr_pair_out);
				end
				replies_checked <= replies_checked + 1;
				recv_wait = (((replies_checked / 250) % 3) == 1) ? 0 : $urandom_range(0, 3);
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Hold off the receiver for a long stretch now and then to back up the pipe
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			next_hold_at <= 400;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (replies_checked >= next_hold_at) begin
			hold_left <= 300;
			next_hold_at <= next_hold_at + 800;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		hrw_pkg::in_fields_t h;
		int pick;
		logic [1:0] mode;

		// all ones and all zeros in every field
		h = '1;
		queue_header(hrw_pkg::FUNC_REPLY, h);
		queue_header(hrw_pkg::FUNC_CONTINUE, h);
		h = '0;
		queue_header(hrw_pkg::FUNC_REPLY, h);
		queue_header(hrw_pkg::FUNC_CONTINUE, h);
		// timestamp option present, at the smallest and largest offsets
		queue_case(hrw_pkg::FUNC_REPLY, hrw_pkg::TS_MIN_WORDS,
			{hrw_pkg::TS_KIND, hrw_pkg::TS_LEN});
		queue_case(hrw_pkg::FUNC_REPLY, 4'd15, {hrw_pkg::TS_KIND, hrw_pkg::TS_LEN});
		// option word off by one in kind or length: no swap
		queue_case(hrw_pkg::FUNC_REPLY, hrw_pkg::TS_MIN_WORDS,
			{hrw_pkg::TS_KIND, hrw_pkg::TS_LEN - 8'd1});
		queue_case(hrw_pkg::FUNC_REPLY, hrw_pkg::TS_MIN_WORDS,
			{hrw_pkg::TS_KIND - 8'd1, hrw_pkg::TS_LEN});
		// header of 20 to 31 bytes: no timestamp change
		queue_case(hrw_pkg::FUNC_REPLY, 4'd7, {hrw_pkg::TS_KIND, hrw_pkg::TS_LEN});
		queue_case(hrw_pkg::FUNC_CONTINUE, 4'd7, {hrw_pkg::TS_KIND, hrw_pkg::TS_LEN});
		queue_case(hrw_pkg::FUNC_REPLY, hrw_pkg::MIN_HDR_WORDS,
			{hrw_pkg::TS_KIND, hrw_pkg::TS_LEN});
		// continue bumps the value regardless of the option kind
		queue_case(hrw_pkg::FUNC_CONTINUE, hrw_pkg::TS_MIN_WORDS, 16'h0000);
		h = random_header();
		h.header_words  = 4'd15;
		h.stamp_pair_in = {32'hFFFF_FFFF, 32'h1234_5678};
		queue_header(hrw_pkg::FUNC_CONTINUE, h);
		// short header in both modes, with a timestamp option word
		queue_case(hrw_pkg::FUNC_REPLY, 4'd0, {hrw_pkg::TS_KIND, hrw_pkg::TS_LEN});
		queue_case(hrw_pkg::FUNC_CONTINUE, 4'd4, {hrw_pkg::TS_KIND, hrw_pkg::TS_LEN});
		// invalid modes, one of them with a short header too
		queue_case(2'd2, hrw_pkg::TS_MIN_WORDS, {hrw_pkg::TS_KIND, hrw_pkg::TS_LEN});
		queue_case(2'd3, 4'd0, {hrw_pkg::TS_KIND, hrw_pkg::TS_LEN});
		// wrap of seq, ack, total length and ident
		h = random_header();
		h.seq_in            = 32'hFFFF_FFFF;
		h.payload_len       = 16'hFFFF;
		h.l3_to_payload_len = 16'hFFFF;
		h.ident_in          = 16'hFFFF;
		queue_header(hrw_pkg::FUNC_REPLY, h);
		queue_header(hrw_pkg::FUNC_CONTINUE, h);

		// random part: mostly valid modes and long headers, real options in half
		repeat (1850) begin
			pick = $urandom_range(0, 9);
			mode = (pick < 4) ? hrw_pkg::FUNC_REPLY :
			       (pick < 8) ? hrw_pkg::FUNC_CONTINUE : 2'(pick - 6);
			h = random_header();
			pick = $urandom_range(0, 19);
			if (pick < 14)
				h.header_words = 4'($urandom_range(hrw_pkg::TS_MIN_WORDS, 15));
			else if (pick < 17)
				h.header_words = 4'($urandom_range(hrw_pkg::MIN_HDR_WORDS,
					hrw_pkg::TS_MIN_WORDS - 1));
			else
				h.header_words = 4'($urandom_range(0, hrw_pkg::MIN_HDR_WORDS - 1));
			pick = $urandom_range(0, 19);
			if (pick < 10)
				h.option_kind_len = {hrw_pkg::TS_KIND, hrw_pkg::TS_LEN};
			else if (pick < 13)
				h.option_kind_len[15:8] = hrw_pkg::TS_KIND;
			else if (pick < 16)
				h.option_kind_len[7:0] = hrw_pkg::TS_LEN;
			queue_header(mode, h);
		end

		// single reset pulse
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every item to go in and every result to come out
		while (headers_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		while (rewrites_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (!mismatch_seen && rewrites_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/hrw_pkg.sv
rtl/core/hrw_rewrite.sv
rtl/core/tcp_ip_reply_header_rewrite_unit.sv
rtl/core/hrw_checker.sv
sim/tb.sv
